### src/ame_pkg.sv
// Shared types, codes and sizing constants for the accumulator machine execute unit.
`timescale 1ns / 1ps

package ame_pkg;

  // Number of data words in the machine (16 to 128).
  localparam int DATA_WORDS = 128;
  // Index width of the data memory.
  localparam int MEM_AW = $clog2(DATA_WORDS);
  // Width of the allocation count, which must be able to hold DATA_WORDS.
  localparam int WD_W = $clog2(DATA_WORDS + 1);

  // Instruction codes.
  localparam logic [3:0] OP_DECLARE  = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_LOADIMM  = 4'd2;
  localparam logic [3:0] OP_STORE    = 4'd3;
  localparam logic [3:0] OP_EXCHANGE = 4'd4;
  localparam logic [3:0] OP_JUMP     = 4'd5;
  localparam logic [3:0] OP_JUMPZERO = 4'd6;
  localparam logic [3:0] OP_ADD      = 4'd7;
  localparam logic [3:0] OP_SUB      = 4'd8;
  localparam logic [3:0] OP_HALT     = 4'd9;
  localparam logic [3:0] OP_RESET    = 4'd10;

  // Fault codes.
  localparam logic [2:0] FAULT_OK         = 3'd0;
  localparam logic [2:0] FAULT_FULL       = 3'd1;
  localparam logic [2:0] FAULT_UNDECLARED = 3'd2;
  localparam logic [2:0] FAULT_JUMP       = 3'd3;
  localparam logic [2:0] FAULT_OVERFLOW   = 3'd4;

  // Program counter value of a halted machine, and the first illegal jump target.
  localparam logic [7:0] HALT_PC    = 8'd128;
  localparam logic [7:0] JUMP_LIMIT = 8'd128;

  typedef struct packed {
    logic        [3:0]  func;
    logic        [6:0]  data_address;
    logic signed [15:0] immediate;
    logic        [7:0]  jump_target;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] acc_value;
    logic signed [15:0] second_value;
    logic               zero_flag;
    logic        [7:0]  prog_counter;
    logic        [6:0]  new_address;
    logic        [2:0]  fault;
  } out_item_t;

  // One write into the data memory.
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [15:0]       data;
  } mem_wr_t;

endpackage

### src/ame_dmem.sv
// Data word memory with registered read and same-edge write bypass.
`timescale 1ns / 1ps

module ame_dmem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [ame_pkg::MEM_AW-1:0] rd_addr,
  input  ame_pkg::mem_wr_t           wr,
  output logic [15:0]                rd_data
);

  logic [15:0] mem [ame_pkg::DATA_WORDS];
  logic [15:0] rd_q_r;
  logic [15:0] byp_data_r;
  logic        byp_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      byp_data_r <= wr.data;
    end
  end

  // A read that meets a write to the same word at the same edge sees the new data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr.en && (wr.addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

### src/accumulator_machine_execute.sv
// Top level of the accumulator machine execute unit.
// Usage:
// One instruction enters per input transfer on in_valid / in_stall / in_data and
// produces exactly one result transfer on out_valid / out_stall / out_data that
// shows registers A and B, the zero bit, the program counter, the address given
// out by a declare and a fault code, all as they stand after the instruction.
// An instruction passes the capture stage, which takes it and reads the data
// memory, then the execute step, which runs it against the machine state and
// loads the result register. Throughput is one instruction per cycle while
// out_stall is low, set by the single data memory port and the 16-bit add in the
// execute step; a new instruction is taken while the previous result still waits.
// When the receiver holds out_stall, the result register keeps its transfer, the
// captured instruction waits, and in_stall rises once that stage is occupied.
// Reset (rst_n low, synchronous) clears A, B, the zero bit, the program counter,
// the allocation count and both pipeline stages. Data words are not swept: a word
// can only be read after a declare has cleared it, so no clearing pass is needed.
// The reset instruction returns A, B, the zero bit, the program counter and the allocation count to the same state.
`timescale 1ns / 1ps

module accumulator_machine_execute (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ame_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ame_pkg::out_item_t out_data
);

  // Capture stage: holds an instruction whose memory read is under way.
  logic               s1_valid_r;
  ame_pkg::in_item_t  s1_item_r;

  // Result stage.
  logic               out_valid_r;
  ame_pkg::out_item_t out_item_r;

  // Architectural machine state.
  logic [15:0]               acc_r;
  logic [15:0]               sec_r;
  logic                      zero_r;
  logic [7:0]                pc_r;
  logic [ame_pkg::WD_W-1:0]  wd_r;

  logic [15:0]               acc_nxt;
  logic [15:0]               sec_nxt;
  logic                      zero_nxt;
  logic [7:0]                pc_nxt;
  logic [ame_pkg::WD_W-1:0]  wd_nxt;
  ame_pkg::out_item_t        out_item_nxt;

  logic                      in_accept;
  logic                      advance;
  logic [15:0]               rd_data;
  ame_pkg::mem_wr_t          mem_wr;

  // The captured instruction executes whenever the result register is free or
  // its transfer completes at this edge.
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  ame_dmem u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (in_data.data_address[ame_pkg::MEM_AW-1:0]),
    .wr      (mem_wr),
    .rd_data (rd_data)
  );

  // Execute step. Every path is a compare, a 16-bit add or subtract, and a mux.
  always_comb begin
    logic        addr_ok;
    logic        decl_ok;
    logic [16:0] sum;
    logic        ovf;
    logic [2:0]  fault;
    logic [6:0]  new_addr;

    addr_ok  = {1'b0, s1_item_r.data_address} < 8'(wd_r);
    decl_ok  = wd_r < ame_pkg::WD_W'(ame_pkg::DATA_WORDS);
    sum      = (s1_item_r.func == ame_pkg::OP_SUB)
             ? {acc_r[15], acc_r} - {sec_r[15], sec_r}
             : {acc_r[15], acc_r} + {sec_r[15], sec_r};
    ovf      = sum[16] != sum[15];
    fault    = ame_pkg::FAULT_OK;
    new_addr = 7'd0;

    acc_nxt  = acc_r;
    sec_nxt  = sec_r;
    zero_nxt = zero_r;
    pc_nxt   = pc_r;
    wd_nxt   = wd_r;
    mem_wr   = '{en: 1'b0, addr: s1_item_r.data_address[ame_pkg::MEM_AW-1:0],
                 data: acc_r};

    case (s1_item_r.func)
      ame_pkg::OP_DECLARE: begin
        if (decl_ok) begin
          // The new word is cleared as it is handed out.
          new_addr    = 7'(wd_r);
          mem_wr.en   = 1'b1;
          mem_wr.addr = wd_r[ame_pkg::MEM_AW-1:0];
          mem_wr.data = 16'd0;
          wd_nxt      = wd_r + 1'b1;
        end else begin
          fault = ame_pkg::FAULT_FULL;
        end
      end
      ame_pkg::OP_LOAD: begin
        if (addr_ok) begin
          acc_nxt = rd_data;
        end else begin
          fault = ame_pkg::FAULT_UNDECLARED;
        end
      end
      ame_pkg::OP_LOADIMM: begin
        acc_nxt = s1_item_r.immediate;
      end
      ame_pkg::OP_STORE: begin
        if (addr_ok) begin
          mem_wr.en = 1'b1;
        end else begin
          fault = ame_pkg::FAULT_UNDECLARED;
        end
      end
      ame_pkg::OP_EXCHANGE: begin
        acc_nxt = sec_r;
        sec_nxt = acc_r;
      end
      ame_pkg::OP_JUMP, ame_pkg::OP_JUMPZERO: begin
        if (s1_item_r.func == ame_pkg::OP_JUMPZERO && !zero_r) begin
          pc_nxt = pc_r + 8'd1;
        end else if (s1_item_r.jump_target < ame_pkg::JUMP_LIMIT) begin
          pc_nxt = s1_item_r.jump_target;
        end else begin
          fault = ame_pkg::FAULT_JUMP;
        end
      end
      ame_pkg::OP_ADD, ame_pkg::OP_SUB: begin
        if (ovf) begin
          fault = ame_pkg::FAULT_OVERFLOW;
        end else begin
          acc_nxt  = sum[15:0];
          zero_nxt = sum[15:0] == 16'd0;
        end
      end
      ame_pkg::OP_HALT: begin
        pc_nxt = ame_pkg::HALT_PC;
      end
      ame_pkg::OP_RESET: begin
        // Words beyond the count become unreadable, so the memory is left alone.
        acc_nxt  = 16'd0;
        sec_nxt  = 16'd0;
        zero_nxt = 1'b0;
        pc_nxt   = 8'd0;
        wd_nxt   = '0;
      end
      default: begin
      end
    endcase

    // Nothing changes unless the instruction really executes this cycle.
    mem_wr.en = mem_wr.en && advance;

    out_item_nxt = '{acc_value: acc_nxt, second_value: sec_nxt, zero_flag: zero_nxt,
                     prog_counter: pc_nxt, new_address: new_addr, fault: fault};
  end

  // Capture stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
    end
  end

  // Machine state and result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 16'd0;
      sec_r       <= 16'd0;
      zero_r      <= 1'b0;
      pc_r        <= 8'd0;
      wd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        acc_r       <= acc_nxt;
        sec_r       <= sec_nxt;
        zero_r      <= zero_nxt;
        pc_r        <= pc_nxt;
        wd_r        <= wd_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

`ifndef SYNTHESIS
  // The allocation count never passes the size of the memory.
  a_wd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wd_r <= ame_pkg::WD_W'(ame_pkg::DATA_WORDS))
    else $error("allocation count beyond memory size");

  // A held result must not be overwritten by the next instruction.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !advance)
    else $error("result overwritten while stalled");

  // A full-memory fault never reports an allocated address.
  a_full_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.fault == ame_pkg::FAULT_FULL) |->
      out_item_r.new_address == 7'd0)
    else $error("address reported with memory-full fault");

  // A successful declare bumps the allocation count by one.
  a_decl_count: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_item_r.func == ame_pkg::OP_DECLARE &&
     wd_r < ame_pkg::WD_W'(ame_pkg::DATA_WORDS)) |=> wd_r == $past(wd_r) + 1'b1)
    else $error("declare did not advance allocation count");
`endif

endmodule
